FILE: design/rle_byte_decoder_unit_defines.svh
// Assertion macros shared by the run-length byte decoder modules.
// No dependencies; include with the bare file name.
`ifndef RLE_BYTE_DECODER_UNIT_DEFINES_SVH
`define RLE_BYTE_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RBD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rbd assertion failed");

// Next-cycle implication, checked outside reset.
`define RBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rbd assertion failed");

`endif

FILE: design/rbd_pkg.sv
// Shared types and constants for the run-length byte decoder.
// No dependencies; imported by every module of the block.
package rbd_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 13;
    localparam int HIGH_W  = 5;
    localparam int SEEN_W  = 15;

    // Only this many stream bytes after reset are decoded.
    localparam logic [SEEN_W-1:0] SOURCE_LIMIT = SEEN_W'(24576 - 512);

    localparam int CMD_LONG_BIT = 7;
    localparam logic [BYTE_W-1:0] CMD_END    = 8'h00;
    localparam logic [BYTE_W-1:0] FILL_ZERO  = 8'h00;
    localparam logic [BYTE_W-1:0] FILL_ONES  = 8'hFF;

    typedef enum logic [1:0] {
        KIND_ZERO    = 2'd0,
        KIND_PATTERN = 2'd1,
        KIND_LITERAL = 2'd2,
        KIND_ONES    = 2'd3
    } t_kind;

    typedef struct packed {
        logic               valid;
        logic [BYTE_W-1:0]  value;
        logic [COUNT_W-1:0] count;
        logic               stream_end;
    } t_result;

endpackage

FILE: design/rbd_in_reg.sv
// Input register stage of the run-length byte decoder.
// Depends on rbd_pkg.
module rbd_in_reg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [rbd_pkg::BYTE_W-1:0] i_byte,
    output logic                      o_ready,
    input  logic                      i_space,
    output logic                      o_valid,
    output logic [rbd_pkg::BYTE_W-1:0] o_byte
);
    import rbd_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    // Accept when empty or when the held item moves on this cycle.
    assign o_ready = !r_valid || i_space;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

FILE: design/rbd_decode.sv
// Stream state and command decode of the run-length byte decoder.
// Depends on rbd_pkg and the assertion macro header.
`include "rle_byte_decoder_unit_defines.svh"

module rbd_decode (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic [rbd_pkg::BYTE_W-1:0] i_byte,
    output rbd_pkg::t_result           o_result
);
    import rbd_pkg::*;

    typedef enum logic [2:0] {
        PH_COMMAND,
        PH_COUNT_LO,
        PH_PATTERN,
        PH_LITERAL,
        PH_DONE
    } t_phase;

    t_phase             r_phase,        n_phase;
    t_kind              r_run_kind,     n_run_kind;
    logic [HIGH_W-1:0]  r_count_high,   n_count_high;
    logic [COUNT_W-1:0] r_literal_left, n_literal_left;
    logic [SEEN_W-1:0]  r_bytes_seen,   n_bytes_seen;

    t_kind              d_kind;
    logic [COUNT_W-1:0] d_count;
    logic               d_go;
    logic [COUNT_W-1:0] left_dec;
    t_result            res;

    assign left_dec = r_literal_left - COUNT_W'(1);

    always_comb begin
        n_phase        = r_phase;
        n_run_kind     = r_run_kind;
        n_count_high   = r_count_high;
        n_literal_left = r_literal_left;
        n_bytes_seen   = r_bytes_seen;
        res            = '0;
        d_go           = 1'b0;
        d_kind         = r_run_kind;
        d_count        = {r_count_high, i_byte};

        if (i_fire && r_phase != PH_DONE && r_bytes_seen < SOURCE_LIMIT) begin
            n_bytes_seen = r_bytes_seen + SEEN_W'(1);
            case (r_phase)
                PH_COMMAND: begin
                    if (i_byte == CMD_END) begin
                        n_phase        = PH_DONE;
                        res.valid      = 1'b1;
                        res.stream_end = 1'b1;
                    end else begin
                        n_run_kind   = t_kind'(i_byte[6:5]);
                        n_count_high = i_byte[HIGH_W-1:0];
                        if (i_byte[CMD_LONG_BIT]) begin
                            n_phase = PH_COUNT_LO;
                        end else begin
                            d_go    = 1'b1;
                            d_kind  = t_kind'(i_byte[6:5]);
                            d_count = COUNT_W'(i_byte[HIGH_W-1:0]);
                        end
                    end
                end
                PH_COUNT_LO: begin
                    d_go = 1'b1;
                end
                PH_PATTERN: begin
                    n_phase   = PH_COMMAND;
                    res.valid = (r_literal_left != '0);
                    res.value = i_byte;
                    res.count = r_literal_left;
                end
                PH_LITERAL: begin
                    n_literal_left = left_dec;
                    if (left_dec == '0) begin
                        n_phase = PH_COMMAND;
                    end
                    res.valid = 1'b1;
                    res.value = i_byte;
                    res.count = COUNT_W'(1);
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase

            // Act on a complete count for the pending command kind.
            if (d_go) begin
                case (d_kind)
                    KIND_ZERO: begin
                        n_phase   = PH_COMMAND;
                        res.valid = (d_count != '0);
                        res.value = FILL_ZERO;
                        res.count = d_count;
                    end
                    KIND_ONES: begin
                        n_phase   = PH_COMMAND;
                        res.valid = (d_count != '0);
                        res.value = FILL_ONES;
                        res.count = d_count;
                    end
                    KIND_PATTERN: begin
                        n_literal_left = d_count;
                        n_phase        = PH_PATTERN;
                    end
                    default: begin
                        n_literal_left = d_count;
                        n_phase        = (d_count != '0) ? PH_LITERAL : PH_COMMAND;
                    end
                endcase
            end
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_COMMAND;
            r_run_kind     <= KIND_ZERO;
            r_count_high   <= '0;
            r_literal_left <= '0;
            r_bytes_seen   <= '0;
        end else begin
            r_phase        <= n_phase;
            r_run_kind     <= n_run_kind;
            r_count_high   <= n_count_high;
            r_literal_left <= n_literal_left;
            r_bytes_seen   <= n_bytes_seen;
        end
    end

    `RBD_ASSERT_IMP(a_literal_nonzero, i_clk, i_rst_n, r_phase == PH_LITERAL, r_literal_left != '0)
    `RBD_ASSERT_IMP(a_seen_bounded, i_clk, i_rst_n, 1'b1, r_bytes_seen <= SOURCE_LIMIT)
    `RBD_ASSERT_NEXT(a_done_sticks, i_clk, i_rst_n, r_phase == PH_DONE, r_phase == PH_DONE)

endmodule

FILE: design/rbd_out_reg.sv
// Result register stage of the run-length byte decoder.
// Depends on rbd_pkg.
module rbd_out_reg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rbd_pkg::t_result            i_result,
    input  logic                        i_load,
    output logic                        o_space,
    input  logic                        i_ready,
    output logic                        o_valid,
    output logic [rbd_pkg::BYTE_W-1:0]  o_value,
    output logic [rbd_pkg::COUNT_W-1:0] o_count,
    output logic                        o_stream_end
);
    import rbd_pkg::*;

    logic               r_valid;
    logic [BYTE_W-1:0]  r_value;
    logic [COUNT_W-1:0] r_count;
    logic               r_stream_end;

    // Room for a new result when empty or when the held one is taken now.
    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load && i_result.valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_result.valid) begin
            r_value      <= i_result.value;
            r_count      <= i_result.count;
            r_stream_end <= i_result.stream_end;
        end
    end

    assign o_valid      = r_valid;
    assign o_value      = r_value;
    assign o_count      = r_count;
    assign o_stream_end = r_stream_end;

endmodule

FILE: design/rle_byte_decoder_unit.sv
// Top level of the run-length byte decoder: input register, decode, result register.
// Depends on rbd_pkg, rbd_in_reg, rbd_decode, rbd_out_reg and the macro header.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------------
//   in      | to block  | i_valid / o_ready  | i_in_byte
//   out     | from block| o_valid / i_ready  | o_out_value, o_repeat_count, o_stream_end
//
// One item per cycle sustained while the out channel is not stalled; the input register
// takes each item as it is accepted, and the result register loads the item's decoded
// result, if it yields one, when the item is fired from the input register into decode.
// Reset (i_rst_n low at a clock edge) empties both registers and returns the decoder
// to expecting a command byte, with the stream byte count cleared.
// A stall on the out channel holds the result register; the input register takes one more
// item if it is empty, then o_ready drops until the result is taken.
`include "rle_byte_decoder_unit_defines.svh"

module rle_byte_decoder_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rbd_pkg::BYTE_W-1:0]  i_in_byte,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rbd_pkg::BYTE_W-1:0]  o_out_value,
    output logic [rbd_pkg::COUNT_W-1:0] o_repeat_count,
    output logic                        o_stream_end
);
    import rbd_pkg::*;

    logic              stage_valid;
    logic [BYTE_W-1:0] stage_byte;
    logic              out_space;
    logic              fire;
    t_result           result;

    // Advance the held item into decode whenever the result register has room.
    assign fire = stage_valid && out_space;

    rbd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_byte  (i_in_byte),
        .o_ready (o_ready),
        .i_space (out_space),
        .o_valid (stage_valid),
        .o_byte  (stage_byte)
    );

    // Consume one stream byte per fire; emit at most one result.
    rbd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (stage_byte),
        .o_result (result)
    );

    // Hold the result until the downstream side takes it.
    rbd_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_result     (result),
        .i_load       (fire),
        .o_space      (out_space),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_value      (o_out_value),
        .o_count      (o_repeat_count),
        .o_stream_end (o_stream_end)
    );

    `RBD_ASSERT_IMP(a_end_is_empty, i_clk, i_rst_n, o_valid && o_stream_end, o_out_value == '0 && o_repeat_count == '0)
    `RBD_ASSERT_IMP(a_run_nonzero, i_clk, i_rst_n, o_valid && !o_stream_end, o_repeat_count != '0)
    `RBD_ASSERT_NEXT(a_nothing_after_end, i_clk, i_rst_n, o_valid && i_ready && o_stream_end, !o_valid)

endmodule
